// ===== hdl/deqs_pkg.sv =====
// Shared types and constants for the double-ended queue with search.
// Command codes, status codes, stream widths and controller/datapath structs.
// No dependencies.
package deqs_pkg;

  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;

  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SEARCH     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic                load;
    logic                wr_front;
    logic                wr_back;
    logic                rd_front;
    logic                rd_back;
    logic                search_start;
    logic                rd_next;
    logic                pop_front;
    logic                pop_back;
    logic                hit;
    logic                res_set;
    logic [STATUS_W-1:0] res_status;
    logic                out_load;
  } deqs_cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                full;
    logic                empty;
    logic                match;
    logic                last;
    logic                out_free;
  } deqs_stat_t;

endpackage

// ===== hdl/deqs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependencies.
module deqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/deqs_ctrl.sv =====
// Controller state machine for the double-ended queue with search.
// Issues datapath commands from status; depends on deqs_pkg.
module deqs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  deqs_pkg::deqs_stat_t stat,
  output deqs_pkg::deqs_cmd_t  cmd
);
  import deqs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_RESP;
        cmd.res_set = 1'b1;
        cmd.res_status = ST_OK;
        case (stat.op)
          OP_PUSH_FRONT: begin
            if (stat.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.wr_front = 1'b1;
            end
          end
          OP_PUSH_BACK: begin
            if (stat.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.wr_back = 1'b1;
            end
          end
          OP_POP_FRONT: begin
            if (stat.empty) begin
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.res_set  = 1'b0;
              cmd.rd_front = 1'b1;
              state_next   = S_POP;
            end
          end
          OP_POP_BACK: begin
            if (stat.empty) begin
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.res_set = 1'b0;
              cmd.rd_back = 1'b1;
              state_next  = S_POP;
            end
          end
          OP_SEARCH: begin
            if (stat.empty) begin
              cmd.res_status = ST_NOT_FOUND;
            end else begin
              cmd.res_set      = 1'b0;
              cmd.search_start = 1'b1;
              state_next       = S_SRCH;
            end
          end
          default: begin
            cmd.res_status = ST_OK;
          end
        endcase
      end
      S_POP: begin
        if (stat.op == OP_POP_FRONT) begin
          cmd.pop_front = 1'b1;
        end else begin
          cmd.pop_back = 1'b1;
        end
        state_next = S_RESP;
      end
      S_SRCH: begin
        if (stat.match) begin
          cmd.hit    = 1'b1;
          state_next = S_RESP;
        end else if (stat.last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          state_next     = S_RESP;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/deqs_dp.sv =====
// Datapath for the double-ended queue with search: pointers, element RAM,
// search scan, result and output registers. Depends on deqs_pkg, deqs_ram.
module deqs_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [deqs_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [deqs_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  input  deqs_pkg::deqs_cmd_t                 cmd,
  output deqs_pkg::deqs_stat_t                stat
);
  import deqs_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [IW-1:0]              front;
  logic [CW-1:0]              count;
  logic [CW-1:0]              idx;
  logic [OPCODE_W-1:0]        op_q;
  logic signed [VALUE_W-1:0]  val_q;
  logic [STATUS_W-1:0]        res_status;
  logic signed [VALUE_W-1:0]  res_removed;
  logic [POS_W-1:0]           res_pos;
  logic [STATUS_W-1:0]        out_status;
  logic signed [VALUE_W-1:0]  out_removed;
  logic [POS_W-1:0]           out_pos;

  logic [IW-1:0]              slot_prev;
  logic [IW-1:0]              slot_next;
  logic [IW-1:0]              slot_tail;
  logic [IW-1:0]              slot_last;
  logic [IW-1:0]              slot_scan;
  logic [CW-1:0]              idx_inc;
  logic [PW-1:0]              pos_full;

  logic                       ram_we;
  logic [IW-1:0]              ram_waddr;
  logic                       ram_re;
  logic [IW-1:0]              ram_raddr;
  logic [VALUE_W-1:0]         ram_rdata;

  function automatic logic [IW-1:0] slot_at(input logic [IW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [IW:0] sum;
    sum = (IW+1)'(base) + (IW+1)'(off);
    if (sum >= (IW+1)'(CAPACITY)) begin
      sum = sum - (IW+1)'(CAPACITY);
    end
    return sum[IW-1:0];
  endfunction

  assign idx_inc   = idx + CW'(1);
  assign slot_prev = slot_at(front, CW'(CAPACITY - 1));
  assign slot_next = slot_at(front, CW'(1));
  assign slot_tail = slot_at(front, count);
  assign slot_last = slot_at(front, count - CW'(1));
  assign slot_scan = slot_at(front, idx_inc);
  assign pos_full  = PW'(idx) + PW'(1);

  assign ram_we    = cmd.wr_front | cmd.wr_back;
  assign ram_waddr = cmd.wr_front ? slot_prev : slot_tail;
  assign ram_re    = cmd.rd_front | cmd.search_start | cmd.rd_back | cmd.rd_next;

  always_comb begin
    if (cmd.rd_back) begin
      ram_raddr = slot_last;
    end else if (cmd.rd_next) begin
      ram_raddr = slot_scan;
    end else begin
      ram_raddr = front;
    end
  end

  deqs_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(val_q),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front         <= '0;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cmd.wr_front) begin
        front <= slot_prev;
        count <= count + CW'(1);
      end else if (cmd.wr_back) begin
        count <= count + CW'(1);
      end else if (cmd.pop_front) begin
        front <= slot_next;
        count <= count - CW'(1);
      end else if (cmd.pop_back) begin
        count <= count - CW'(1);
      end
      if (cmd.out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= s_axis_tdata[OPCODE_W-1:0];
      val_q <= s_axis_tdata[OPCODE_W +: VALUE_W];
    end
    if (cmd.search_start) begin
      idx <= '0;
    end else if (cmd.rd_next) begin
      idx <= idx_inc;
    end
    if (cmd.res_set) begin
      res_status  <= cmd.res_status;
      res_removed <= '0;
      res_pos     <= '0;
    end else if (cmd.pop_front || cmd.pop_back) begin
      res_status  <= ST_OK;
      res_removed <= ram_rdata;
      res_pos     <= '0;
    end else if (cmd.hit) begin
      res_status  <= ST_OK;
      res_removed <= '0;
      res_pos     <= pos_full[POS_W-1:0];
    end
    if (cmd.out_load) begin
      out_status  <= res_status;
      out_removed <= res_removed;
      out_pos     <= res_pos;
    end
  end

  assign m_axis_tdata = {1'b0, out_pos, out_removed, out_status};

  assign stat.op       = op_q;
  assign stat.full     = (count == CW'(CAPACITY));
  assign stat.empty    = (count == '0);
  assign stat.match    = (ram_rdata == val_q);
  assign stat.last     = (idx_inc == count);
  assign stat.out_free = !m_axis_tvalid || m_axis_tready;

endmodule

// ===== hdl/double_ended_queue_with_search_unit.sv =====
// Top level of the double-ended queue with search.
// Joins deqs_ctrl and deqs_dp; depends on deqs_pkg.
//
// Holds up to CAPACITY signed 32-bit values in front-to-back order and runs one
// command per input transaction: push front, push back, pop front, pop back or
// search by value, answering each with exactly one output transaction. After
// acceptance a command passes the execute state, then the pop read state for
// a pop or the search state for a search, then the response state, which
// moves the result into the output register once that register is free. The
// search scans the element RAM through its single read port one entry per
// cycle; the position of the first match sets the scan length. A push, a
// failed pop, an empty search or an unused opcode skips to the response state.
// The next command is accepted once the previous result has moved into the
// output register, even if that result is still waiting on m_axis_tready.
// The element RAM needs no clearing after reset.
module double_ended_queue_with_search_unit #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[2:0], value[34:3], zero[39:35]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], removed_value[33:2], position[38:34], zero[39]
  output logic [39:0] m_axis_tdata
);
  import deqs_pkg::*;

  deqs_cmd_t  cmd;
  deqs_stat_t stat;

  deqs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .stat         (stat),
    .cmd          (cmd)
  );

  deqs_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

// ===== hdl/deqs_chk.sv =====
// Port-level checker for the double-ended queue with search, bound to the top.
// Depends on deqs_pkg.
module deqs_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  import deqs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a command is in progress");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK)
      |-> (m_axis_tdata[33:2] == '0) && (m_axis_tdata[38:34] == '0))
    else $error("failed command returned a value or position");

  a_pop_no_pos: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[33:2] != '0) |-> (m_axis_tdata[38:34] == '0))
    else $error("pop result carries a search position");

endmodule

bind double_ended_queue_with_search_unit deqs_chk u_deqs_chk (.*);
